// ===== design/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit heap allocator: header entry
// layout, memory write port bundle, heap geometry and status codes.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int HEAP_BYTES    = 65536;
    localparam int HEADER_BYTES  = 20;
    localparam int PAGE_BYTES    = 4096;
    localparam int INITIAL_BYTES = 16384;
    localparam int MIN_REST      = 16;
    localparam int ALIGN_BYTES   = 8;
    localparam int GRAIN         = 4;
    localparam int DEPTH         = HEAP_BYTES / GRAIN;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int OFF_W         = 16;
    localparam int SIZE_W        = 17;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NULL    = 3'd1;
    localparam logic [2:0] ST_NOSPACE = 3'd2;
    localparam logic [2:0] ST_BADPTR  = 3'd3;
    localparam logic [2:0] ST_DOUBLE  = 3'd4;

    typedef struct packed {
        logic              valid;
        logic              is_free;
        logic              is_last;
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  prev;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } mem_wr_t;

endpackage

// ===== design/ffa_mem.sv =====
// ----------------------------------------------------------------------------
// ffa_mem
// Header table: one entry per grain, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffa_mem
    import ffa_pkg::*;
(
    input  logic             clk,
    input  mem_wr_t          wr,
    input  logic [IDX_W-1:0] rd_idx,
    output entry_t           rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.idx] <= wr.data;
        end
        rd_data <= mem[rd_idx];
    end

endmodule

// ===== design/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: clears the header table after reset, walks the chain for
// allocation, splits and grows blocks, and frees with coalescing.
// ----------------------------------------------------------------------------
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [15:0]       request_size,
    input  logic [15:0]       block_address,
    input  logic [16:0]       max_bytes,
    output mem_wr_t           wr,
    output logic [IDX_W-1:0]  rd_idx,
    input  entry_t            rd_data,
    output logic              res_valid,
    input  logic              res_take,
    output logic [15:0]       res_addr,
    output logic [2:0]        res_status
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ACHK  = 4'd2;
    localparam logic [3:0] S_AFIX  = 4'd3;
    localparam logic [3:0] S_AWE   = 4'd4;
    localparam logic [3:0] S_AGROW = 4'd5;
    localparam logic [3:0] S_ARD   = 4'd6;
    localparam logic [3:0] S_FCHK  = 4'd7;
    localparam logic [3:0] S_FNXT  = 4'd8;
    localparam logic [3:0] S_FWE   = 4'd9;
    localparam logic [3:0] S_FPCHK = 4'd10;
    localparam logic [3:0] S_FFIX  = 4'd11;
    localparam logic [3:0] S_FFIX2 = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    localparam logic [17:0] HDR18  = 18'(HEADER_BYTES);
    localparam logic [18:0] PMASK  = 19'(PAGE_BYTES - 1);

    logic [3:0]        state_reg, state_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [SIZE_W-1:0] sz_reg, sz_next;
    entry_t            e_reg, e_next;
    logic              split_reg, split_next;
    logic              nmrg_reg, nmrg_next;
    logic              pmrg_reg, pmrg_next;
    logic [16:0]       mapped_end_reg, mapped_end_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [15:0]       res_addr_reg, res_addr_next;
    logic [2:0]        res_st_reg, res_st_next;

    logic [17:0]       rd_next_b;
    logic [17:0]       e_next_b;
    logic [17:0]       split_noff;
    logic [17:0]       need_b;
    logic [17:0]       new_end;
    logic [18:0]       rounded;
    logic [16:0]       lim;
    logic [15:0]       free_off;
    entry_t            init_e;

    always_comb
    begin
        rd_next_b  = 18'(off_reg) + HDR18 + 18'(rd_data.size);
        e_next_b   = 18'(off_reg) + HDR18 + 18'(e_reg.size);
        split_noff = 18'(off_reg) + HDR18 + 18'(sz_reg);
        need_b     = 18'(sz_reg) + HDR18;
        new_end    = 18'(mapped_end_reg) + need_b;
        rounded    = (19'(new_end) + PMASK) & ~PMASK;
        lim        = (max_bytes > 17'(HEAP_BYTES)) ? 17'(HEAP_BYTES) : max_bytes;
        free_off   = block_address - 16'(HEADER_BYTES);
        init_e          = '0;
        init_e.valid    = 1'b1;
        init_e.is_free  = 1'b1;
        init_e.is_last  = 1'b1;
        init_e.size     = 17'(INITIAL_BYTES - HEADER_BYTES);
    end

    always_comb
    begin
        state_next      = state_reg;
        off_next        = off_reg;
        sz_next         = sz_reg;
        e_next          = e_reg;
        split_next      = split_reg;
        nmrg_next       = nmrg_reg;
        pmrg_next       = pmrg_reg;
        mapped_end_next = mapped_end_reg;
        clr_next        = clr_reg;
        res_addr_next   = res_addr_reg;
        res_st_next     = res_st_reg;
        wr              = '0;
        rd_idx          = off_reg[OFF_W-1:2];
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                wr.we    = 1'b1;
                wr.idx   = clr_reg;
                wr.data  = (clr_reg == '0) ? init_e : '0;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready      = 1'b1;
                res_addr_next = '0;
                nmrg_next     = 1'b0;
                pmrg_next     = 1'b0;
                if (in_valid)
                begin
                    if (!mode)
                    begin
                        if (request_size == '0)
                        begin
                            res_st_next = ST_NULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            sz_next    = (17'(request_size) + 17'(ALIGN_BYTES - 1))
                                         & ~17'(ALIGN_BYTES - 1);
                            off_next   = '0;
                            rd_idx     = '0;
                            state_next = S_ACHK;
                        end
                    end
                    else if (block_address == '0)
                    begin
                        res_st_next = ST_NULL;
                        state_next  = S_DONE;
                    end
                    else if (block_address < 16'(HEADER_BYTES) || free_off[1:0] != 2'd0)
                    begin
                        res_st_next = ST_BADPTR;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        off_next   = free_off;
                        rd_idx     = free_off[OFF_W-1:2];
                        state_next = S_FCHK;
                    end
                end
            end
            S_ACHK:
            begin
                if (rd_data.is_free && rd_data.size >= sz_reg)
                begin
                    e_next = rd_data;
                    if (18'(rd_data.size) >= split_noff - 18'(off_reg) + 18'(MIN_REST))
                    begin
                        split_next      = 1'b1;
                        wr.we           = 1'b1;
                        wr.idx          = split_noff[OFF_W-1:2];
                        wr.data.valid   = 1'b1;
                        wr.data.is_free = 1'b1;
                        wr.data.is_last = rd_data.is_last;
                        wr.data.size    = 17'(18'(rd_data.size) - need_b);
                        wr.data.prev    = off_reg[OFF_W-1:2];
                        if (!rd_data.is_last)
                        begin
                            rd_idx     = rd_next_b[OFF_W-1:2];
                            state_next = S_AFIX;
                        end
                        else
                        begin
                            state_next = S_AWE;
                        end
                    end
                    else
                    begin
                        split_next = 1'b0;
                        state_next = S_AWE;
                    end
                end
                else if (rd_data.is_last)
                begin
                    if (new_end > 18'(lim))
                    begin
                        res_st_next = ST_NOSPACE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        mapped_end_next = (rounded > 19'(lim)) ? lim : rounded[16:0];
                        wr.we = 1'b1;
                        if (rd_data.is_free)
                        begin
                            wr.idx       = off_reg[OFF_W-1:2];
                            wr.data      = rd_data;
                            wr.data.size = 17'(18'(rd_data.size) + need_b);
                            state_next   = S_ARD;
                        end
                        else
                        begin
                            wr.idx          = rd_next_b[OFF_W-1:2];
                            wr.data.valid   = 1'b1;
                            wr.data.is_free = 1'b1;
                            wr.data.is_last = 1'b1;
                            wr.data.size    = sz_reg;
                            wr.data.prev    = off_reg[OFF_W-1:2];
                            e_next          = rd_data;
                            state_next      = S_AGROW;
                        end
                    end
                end
                else
                begin
                    off_next = rd_next_b[OFF_W-1:0];
                    rd_idx   = rd_next_b[OFF_W-1:2];
                end
            end
            S_AFIX:
            begin
                wr.we      = 1'b1;
                wr.idx     = e_next_b[OFF_W-1:2];
                wr.data    = rd_data;
                wr.data.prev = split_noff[OFF_W-1:2];
                state_next = S_AWE;
            end
            S_AWE:
            begin
                wr.we           = 1'b1;
                wr.idx          = off_reg[OFF_W-1:2];
                wr.data         = e_reg;
                wr.data.is_free = 1'b0;
                if (split_reg)
                begin
                    wr.data.size    = sz_reg;
                    wr.data.is_last = 1'b0;
                end
                res_addr_next = off_reg + 16'(HEADER_BYTES);
                res_st_next   = ST_OK;
                state_next    = S_DONE;
            end
            S_AGROW:
            begin
                wr.we           = 1'b1;
                wr.idx          = off_reg[OFF_W-1:2];
                wr.data         = e_reg;
                wr.data.is_last = 1'b0;
                state_next      = S_ARD;
            end
            S_ARD:
            begin
                state_next = S_ACHK;
            end
            S_FCHK:
            begin
                if (!rd_data.valid)
                begin
                    res_st_next = ST_BADPTR;
                    state_next  = S_DONE;
                end
                else if (rd_data.is_free)
                begin
                    res_st_next = ST_DOUBLE;
                    state_next  = S_DONE;
                end
                else
                begin
                    e_next         = rd_data;
                    e_next.is_free = 1'b1;
                    if (!rd_data.is_last)
                    begin
                        rd_idx     = rd_next_b[OFF_W-1:2];
                        state_next = S_FNXT;
                    end
                    else
                    begin
                        state_next = S_FWE;
                    end
                end
            end
            S_FNXT:
            begin
                if (rd_data.is_free)
                begin
                    e_next.size    = 17'(18'(e_reg.size) + HDR18 + 18'(rd_data.size));
                    e_next.is_last = rd_data.is_last;
                    nmrg_next      = 1'b1;
                end
                state_next = S_FWE;
            end
            S_FWE:
            begin
                wr.we   = 1'b1;
                wr.idx  = off_reg[OFF_W-1:2];
                wr.data = e_reg;
                if (off_reg != '0)
                begin
                    rd_idx     = e_reg.prev;
                    state_next = S_FPCHK;
                end
                else
                begin
                    state_next = S_FFIX;
                end
            end
            S_FPCHK:
            begin
                if (rd_data.is_free)
                begin
                    wr.we           = 1'b1;
                    wr.idx          = e_reg.prev;
                    wr.data         = rd_data;
                    wr.data.size    = 17'(18'(rd_data.size) + HDR18 + 18'(e_reg.size));
                    wr.data.is_last = e_reg.is_last;
                    pmrg_next       = 1'b1;
                end
                state_next = S_FFIX;
            end
            S_FFIX:
            begin
                res_st_next = ST_OK;
                if (!e_reg.is_last && (nmrg_reg || pmrg_reg))
                begin
                    rd_idx     = e_next_b[OFF_W-1:2];
                    state_next = S_FFIX2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FFIX2:
            begin
                wr.we        = 1'b1;
                wr.idx       = e_next_b[OFF_W-1:2];
                wr.data      = rd_data;
                wr.data.prev = pmrg_reg ? e_reg.prev : off_reg[OFF_W-1:2];
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            mapped_end_reg <= 17'(INITIAL_BYTES);
            split_reg      <= 1'b0;
            nmrg_reg       <= 1'b0;
            pmrg_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            mapped_end_reg <= mapped_end_next;
            split_reg      <= split_next;
            nmrg_reg       <= nmrg_next;
            pmrg_reg       <= pmrg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg      <= off_next;
        sz_reg       <= sz_next;
        e_reg        <= e_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
    end

    assign res_addr   = res_addr_reg;
    assign res_status = res_st_reg;

endmodule

// ===== design/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an address-ordered chain of headers kept in a
// single-port-read table; frees coalesce with free neighbors.
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  tuser: mode; tdata: request_size,
//                                      block_address
//   m_*       out   m_tvalid/m_tready  tdata: payload_address, status
//   cfg_*     in    cfg_wr_en          cfg_wr_data: max_bytes
//
// Allocate walks the chain from offset 0 until a free block fits; a hit may split
// it and relink the following header, a miss at the last header grows the heap.
// Free checks the header, merges free neighbors and relinks the following header.
// One item at a time; the walk is bound by the table's one read per cycle.
// After reset the table is cleared one entry a cycle with s_tready low. A waiting
// result is held in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] request_size, [31:16] block_address
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] payload_address, [18:16] status
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data
);

    logic [16:0]      max_bytes_reg;
    logic             out_valid_reg;
    logic [15:0]      out_addr_reg;
    logic [2:0]       out_st_reg;
    mem_wr_t          wr;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_data;
    logic             res_valid;
    logic             res_take;
    logic [15:0]      res_addr;
    logic [2:0]       res_status;

    ffa_mem u_mem
    (
        .clk     (clk),
        .wr      (wr),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    ffa_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .mode          (s_tuser[0]),
        .request_size  (s_tdata[15:0]),
        .block_address (s_tdata[31:16]),
        .max_bytes     (max_bytes_reg),
        .wr            (wr),
        .rd_idx        (rd_idx),
        .rd_data       (rd_data),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res_addr      (res_addr),
        .res_status    (res_status)
    );

    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= 17'(HEAP_BYTES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_bytes_reg <= cfg_wr_data;
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_addr_reg <= res_addr;
            out_st_reg   <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_st_reg, out_addr_reg};

    ap_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[18:16] != ST_OK |-> m_tdata[15:0] == 16'd0)
        else $error("nonzero address with error status");

    ap_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    ap_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[18:16] <= ST_DOUBLE)
        else $error("status code out of range");

endmodule
